// ===== design/cpkv_pkg.sv =====
// Shared constants and types for the critical path key vertex block.
package cpkv_pkg;

    localparam int VERTICES = 16;
    localparam int VIDX_W   = $clog2(VERTICES);
    localparam int CNT_W    = $clog2(VERTICES + 1);
    localparam int ADDR_W   = $clog2(VERTICES * VERTICES);
    localparam int WEIGHT_W = 8;
    localparam int TIME_W   = 16;
    localparam int LAT_W    = TIME_W + 1;
    localparam int FIELD_VW = 4;
    localparam int KEY_LIM  = (VERTICES < 16) ? VERTICES : 16;

    // Request bundle from the sequencer to the weight matrix.
    typedef struct packed {
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [WEIGHT_W-1:0] wr_data;
        logic [ADDR_W-1:0]   rd_addr;
        logic                clr;
    } wmem_req_t;

endpackage

// ===== design/cpkv_edge_if.sv =====
// Edge item channel: valid/ready handshake plus the edge payload.
interface cpkv_edge_if import cpkv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FIELD_VW-1:0] src_vertex;
    logic [FIELD_VW-1:0] dst_vertex;
    logic [WEIGHT_W-1:0] edge_weight;
    logic                last_edge;

    modport source (
        output valid, src_vertex, dst_vertex, edge_weight, last_edge,
        input  ready
    );
    modport sink (
        input  valid, src_vertex, dst_vertex, edge_weight, last_edge,
        output ready
    );
endinterface

// ===== design/cpkv_key_if.sv =====
// Result item channel: valid/ready handshake plus one key vertex report.
interface cpkv_key_if import cpkv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FIELD_VW-1:0] key_vertex;
    logic [TIME_W-1:0]   path_length;
    logic                found;
    logic                last_result;

    modport source (
        output valid, key_vertex, path_length, found, last_result,
        input  ready
    );
    modport sink (
        input  valid, key_vertex, path_length, found, last_result,
        output ready
    );
endinterface

// ===== design/cpkv_wmem.sv =====
// Weight matrix: one write and one registered read per cycle, per-entry valid bits.
module cpkv_wmem import cpkv_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  wmem_req_t           req,
    output logic [WEIGHT_W-1:0] rd_weight
);

    logic [WEIGHT_W-1:0]            weight_mem [VERTICES*VERTICES];
    logic [VERTICES*VERTICES-1:0]   vld_reg;
    logic [WEIGHT_W-1:0]            rd_data_reg;
    logic                           rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            weight_mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= weight_mem[req.rd_addr];
    end

    // An entry never written since the last clear reads as no edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[req.rd_addr];
            if (req.clr)
            begin
                vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_weight = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== design/critical_path_key_vertices_top.sv =====
// Critical path key vertex finder: edges load one per cycle while idle; the item
// marked last_edge starts a run that counts in-degrees, walks the matrix in
// topological order for earliest times, walks it backward for latest times and
// reports each vertex whose two times agree, lowest index first (or one not-found
// report if none), with the sink's earliest time as path length. Every matrix
// access goes through the single registered read port of the weight matrix, with
// an address state before each use state; the in-degree count visits every
// matrix entry, the forward and backward walks read one row or column per
// ordered vertex, the key scan visits each vertex and results then leave one at
// a time as the output frees. No edge is taken while a run is in progress. The
// matrix is emptied at the end of the run and starts empty after reset, with no
// clearing pass. A finished result waits in the output register while the next job's edges are loaded.
module critical_path_key_vertices_top import cpkv_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    cpkv_edge_if.sink   edges,
    cpkv_key_if.source  keys,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CNT_RD   = 4'd1;
    localparam logic [3:0] ST_CNT_OP   = 4'd2;
    localparam logic [3:0] ST_FWD_ROW  = 4'd3;
    localparam logic [3:0] ST_FWD_RD   = 4'd4;
    localparam logic [3:0] ST_FWD_OP   = 4'd5;
    localparam logic [3:0] ST_BWD_INIT = 4'd6;
    localparam logic [3:0] ST_BWD_ROW  = 4'd7;
    localparam logic [3:0] ST_BWD_RD   = 4'd8;
    localparam logic [3:0] ST_BWD_OP   = 4'd9;
    localparam logic [3:0] ST_KEY_SCAN = 4'd10;
    localparam logic [3:0] ST_EMIT     = 4'd11;

    localparam logic REG_SINK = 1'b0;

    logic [3:0]                 state_reg, state_next;
    logic [FIELD_VW-1:0]        sink_cfg_reg;
    logic [VIDX_W-1:0]          run_sink_reg, run_sink_next;
    logic [VIDX_W-1:0]          i_reg, i_next;
    logic [VIDX_W-1:0]          j_reg, j_next;
    logic [VIDX_W-1:0]          piv_reg, piv_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CNT_W-1:0]           oc_reg, oc_next;
    logic [CNT_W-1:0]           head_reg, head_next;
    logic [TIME_W-1:0]          stime_reg, stime_next;
    logic signed [LAT_W-1:0]    lv_reg, lv_next;
    logic [TIME_W-1:0]          len_reg, len_next;
    logic [KEY_LIM-1:0]         mask_reg, mask_next;

    logic [TIME_W-1:0]          earliest_reg [VERTICES];
    logic [TIME_W-1:0]          earliest_next [VERTICES];
    logic signed [LAT_W-1:0]    latest_reg [VERTICES];
    logic signed [LAT_W-1:0]    latest_next [VERTICES];
    logic [VIDX_W-1:0]          topo_reg [VERTICES];
    logic [VIDX_W-1:0]          topo_next [VERTICES];
    logic [CNT_W-1:0]           pend_reg [VERTICES];
    logic [CNT_W-1:0]           pend_next [VERTICES];

    logic                       out_valid_reg, out_valid_next;
    logic [FIELD_VW-1:0]        out_key_reg, out_key_next;
    logic [TIME_W-1:0]          out_len_reg, out_len_next;
    logic                       out_found_reg, out_found_next;
    logic                       out_last_reg, out_last_next;

    wmem_req_t                  mem_req;
    logic [WEIGHT_W-1:0]        rd_weight;

    logic [VIDX_W-1:0]          t_rd_idx, e_rd_idx, l_rd_idx;
    logic [VIDX_W-1:0]          topo_rd;
    logic [TIME_W-1:0]          e_rd;
    logic signed [LAT_W-1:0]    l_rd;
    logic [CNT_W-1:0]           p_rd;
    logic [VIDX_W-1:0]          rd_row, rd_col;
    logic                       in_acc;
    logic                       cfg_wr;

    cpkv_wmem u_wmem (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mem_req),
        .rd_weight (rd_weight)
    );

    assign in_acc = edges.valid && edges.ready;
    assign edges.ready = (state_reg == ST_IDLE);

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_SINK) ? {28'd0, sink_cfg_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_cfg_reg <= FIELD_VW'(15);
        end
        else if (cfg_wr && (paddr[2] == REG_SINK))
        begin
            sink_cfg_reg <= pwdata[FIELD_VW-1:0];
        end
    end

    // Single read index per small array
    always_comb
    begin
        t_rd_idx = (state_reg == ST_BWD_ROW) ? VIDX_W'(head_reg - CNT_W'(1))
                                             : VIDX_W'(head_reg);
        topo_rd = topo_reg[t_rd_idx];
        case (state_reg)
            ST_FWD_ROW:  e_rd_idx = topo_rd;
            ST_BWD_INIT: e_rd_idx = run_sink_reg;
            ST_KEY_SCAN: e_rd_idx = i_reg;
            default:     e_rd_idx = j_reg;
        endcase
        l_rd_idx = (state_reg == ST_BWD_ROW) ? topo_rd : i_reg;
        e_rd = earliest_reg[e_rd_idx];
        l_rd = latest_reg[l_rd_idx];
        p_rd = pend_reg[j_reg];
        rd_row = (state_reg == ST_FWD_RD) ? piv_reg : i_reg;
        rd_col = (state_reg == ST_BWD_RD) ? piv_reg : j_reg;
    end

    always_comb
    begin
        logic                    out_free;
        logic [CNT_W-1:0]        cnt_sum;
        logic [CNT_W-1:0]        pend_dec;
        logic [TIME_W:0]         t_sum;
        logic [TIME_W-1:0]       t_sat;
        logic signed [LAT_W-1:0] cand;
        logic [KEY_LIM-1:0]      mask_rest;
        logic [FIELD_VW-1:0]     low_idx;

        state_next    = state_reg;
        run_sink_next = run_sink_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        piv_next      = piv_reg;
        cnt_next      = cnt_reg;
        oc_next       = oc_reg;
        head_next     = head_reg;
        stime_next    = stime_reg;
        lv_next       = lv_reg;
        len_next      = len_reg;
        mask_next     = mask_reg;
        earliest_next = earliest_reg;
        latest_next   = latest_reg;
        topo_next     = topo_reg;
        pend_next     = pend_reg;

        out_valid_next = out_valid_reg;
        out_key_next   = out_key_reg;
        out_len_next   = out_len_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;

        mem_req         = '0;
        mem_req.wr_addr = ADDR_W'(edges.src_vertex) * ADDR_W'(VERTICES)
                        + ADDR_W'(edges.dst_vertex);
        mem_req.wr_data = edges.edge_weight;
        mem_req.rd_addr = ADDR_W'(rd_row) * ADDR_W'(VERTICES) + ADDR_W'(rd_col);

        out_free = !out_valid_reg || keys.ready;
        if (out_valid_reg && keys.ready)
        begin
            out_valid_next = 1'b0;
        end

        cnt_sum  = cnt_reg + CNT_W'(rd_weight != '0);
        pend_dec = p_rd - CNT_W'(1);
        t_sum    = {1'b0, stime_reg} + (TIME_W+1)'(rd_weight);
        t_sat    = t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0];
        cand     = lv_reg - $signed({{(LAT_W-WEIGHT_W){1'b0}}, rd_weight});
        mask_rest = mask_reg & (mask_reg - KEY_LIM'(1));
        low_idx  = '0;
        for (int k = KEY_LIM - 1; k >= 0; k--)
        begin
            if (mask_reg[k])
            begin
                low_idx = FIELD_VW'(k);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    mem_req.wr_en = (int'(edges.src_vertex) < VERTICES)
                                 && (int'(edges.dst_vertex) < VERTICES);
                    if (edges.last_edge)
                    begin
                        run_sink_next = (int'(sink_cfg_reg) < VERTICES)
                                      ? VIDX_W'(sink_cfg_reg) : VIDX_W'(VERTICES - 1);
                        i_next     = '0;
                        j_next     = '0;
                        cnt_next   = '0;
                        oc_next    = '0;
                        state_next = ST_CNT_RD;
                    end
                end
            end
            ST_CNT_RD:
            begin
                state_next = ST_CNT_OP;
            end
            ST_CNT_OP:
            begin
                // i walks the tails, j the head whose in-degree is counted
                if (i_reg == VIDX_W'(VERTICES - 1))
                begin
                    pend_next[j_reg]     = cnt_sum;
                    earliest_next[j_reg] = '0;
                    if (cnt_sum == '0)
                    begin
                        topo_next[VIDX_W'(oc_reg)] = j_reg;
                        oc_next = oc_reg + CNT_W'(1);
                    end
                    cnt_next = '0;
                    i_next   = '0;
                    if (j_reg == VIDX_W'(VERTICES - 1))
                    begin
                        head_next  = '0;
                        state_next = ST_FWD_ROW;
                    end
                    else
                    begin
                        j_next     = j_reg + VIDX_W'(1);
                        state_next = ST_CNT_RD;
                    end
                end
                else
                begin
                    cnt_next   = cnt_sum;
                    i_next     = i_reg + VIDX_W'(1);
                    state_next = ST_CNT_RD;
                end
            end
            ST_FWD_ROW:
            begin
                if (head_reg < oc_reg)
                begin
                    piv_next   = topo_rd;
                    stime_next = e_rd;
                    head_next  = head_reg + CNT_W'(1);
                    j_next     = '0;
                    state_next = ST_FWD_RD;
                end
                else
                begin
                    state_next = ST_BWD_INIT;
                end
            end
            ST_FWD_RD:
            begin
                state_next = ST_FWD_OP;
            end
            ST_FWD_OP:
            begin
                if (rd_weight != '0)
                begin
                    if (p_rd != '0)
                    begin
                        pend_next[j_reg] = pend_dec;
                        if ((pend_dec == '0) && (int'(oc_reg) < VERTICES))
                        begin
                            topo_next[VIDX_W'(oc_reg)] = j_reg;
                            oc_next = oc_reg + CNT_W'(1);
                        end
                    end
                    if (t_sat > e_rd)
                    begin
                        earliest_next[j_reg] = t_sat;
                        // a self loop raises the pivot's own time mid-row
                        if (j_reg == piv_reg)
                        begin
                            stime_next = t_sat;
                        end
                    end
                end
                if (j_reg == VIDX_W'(VERTICES - 1))
                begin
                    j_next     = '0;
                    state_next = ST_FWD_ROW;
                end
                else
                begin
                    j_next     = j_reg + VIDX_W'(1);
                    state_next = ST_FWD_RD;
                end
            end
            ST_BWD_INIT:
            begin
                for (int x = 0; x < VERTICES; x++)
                begin
                    latest_next[x] = $signed({1'b0, e_rd});
                end
                len_next   = e_rd;
                head_next  = oc_reg;
                state_next = ST_BWD_ROW;
            end
            ST_BWD_ROW:
            begin
                i_next = '0;
                if (head_reg != '0)
                begin
                    piv_next   = topo_rd;
                    lv_next    = l_rd;
                    head_next  = head_reg - CNT_W'(1);
                    state_next = ST_BWD_RD;
                end
                else
                begin
                    mask_next  = '0;
                    state_next = ST_KEY_SCAN;
                end
            end
            ST_BWD_RD:
            begin
                state_next = ST_BWD_OP;
            end
            ST_BWD_OP:
            begin
                if ((rd_weight != '0) && (cand < l_rd))
                begin
                    latest_next[i_reg] = cand;
                    if (i_reg == piv_reg)
                    begin
                        lv_next = cand;
                    end
                end
                if (i_reg == VIDX_W'(VERTICES - 1))
                begin
                    i_next     = '0;
                    state_next = ST_BWD_ROW;
                end
                else
                begin
                    i_next     = i_reg + VIDX_W'(1);
                    state_next = ST_BWD_RD;
                end
            end
            ST_KEY_SCAN:
            begin
                mask_next[i_reg] = (l_rd == $signed({1'b0, e_rd}));
                if (i_reg == VIDX_W'(KEY_LIM - 1))
                begin
                    i_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    i_next = i_reg + VIDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = len_reg;
                    if (mask_reg == '0)
                    begin
                        // no key vertex at all
                        out_key_next   = '0;
                        out_found_next = 1'b0;
                        out_last_next  = 1'b1;
                        mem_req.clr    = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_key_next   = low_idx;
                        out_found_next = 1'b1;
                        out_last_next  = (mask_rest == '0);
                        mask_next      = mask_rest;
                        if (mask_rest == '0)
                        begin
                            mem_req.clr = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            oc_reg        <= '0;
            head_reg      <= '0;
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            mask_reg      <= '0;
            earliest_reg  <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            oc_reg        <= oc_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            mask_reg      <= mask_next;
            earliest_reg  <= earliest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_sink_reg  <= run_sink_next;
        piv_reg       <= piv_next;
        stime_reg     <= stime_next;
        lv_reg        <= lv_next;
        len_reg       <= len_next;
        latest_reg    <= latest_next;
        topo_reg      <= topo_next;
        pend_reg      <= pend_next;
        out_key_reg   <= out_key_next;
        out_len_reg   <= out_len_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    assign keys.valid       = out_valid_reg;
    assign keys.key_vertex  = out_key_reg;
    assign keys.path_length = out_len_reg;
    assign keys.found       = out_found_reg;
    assign keys.last_result = out_last_reg;

endmodule

// ===== design/cpkv_checker.sv =====
// Port-level checks for the key vertex finder, bound to the top level.
module cpkv_checker import cpkv_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                in_last,
    input logic                out_valid,
    input logic                out_ready,
    input logic [FIELD_VW-1:0] out_key,
    input logic [TIME_W-1:0]   out_len,
    input logic                out_found,
    input logic                out_last
);

    // A run never completes in the cycle after its last edge.
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("edge taken right after the last edge of a job");

    // The empty-run report is always the only and final item of its run.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_found) |-> (out_last && (out_key == '0)))
        else $error("found=0 item not marked final or with nonzero vertex");

    // Within a run, the next key follows at once, ascends and keeps the length.
    a_ascend: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=>
            (out_valid && out_found && (out_len == $past(out_len))
             && (out_key > $past(out_key))))
        else $error("key items out of order or path length changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_key) && $stable(out_len)
             && $stable(out_found) && $stable(out_last)))
        else $error("stalled result item changed");

endmodule

bind critical_path_key_vertices_top cpkv_checker u_cpkv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (edges.valid),
    .in_ready  (edges.ready),
    .in_last   (edges.last_edge),
    .out_valid (keys.valid),
    .out_ready (keys.ready),
    .out_key   (keys.key_vertex),
    .out_len   (keys.path_length),
    .out_found (keys.found),
    .out_last  (keys.last_result)
);

// ===== bench/critical_path_key_vertices_top_test.sv =====
// Self-checking bench for critical_path_key_vertices_top: edge jobs in, key vertex reports out.
module critical_path_key_vertices_top_test import cpkv_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_SINK    = 3'd0;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         TAIL_CYCLES = 2000;
    localparam int         RANDOM_ITEMS = 290;

    typedef enum int {FLOW, COIN, SPARSE, CHOKE} stall_mode_e;

    typedef struct packed {
        logic [FIELD_VW-1:0] vertex;
        logic [TIME_W-1:0]   length;
        logic                found;
        logic                closes;
    } key_report_t;

    // Tracks the loaded graph and the sink, solves each job on its final edge
    // and checks the reports that come back.
    class key_vertex_tracker;
        logic [WEIGHT_W-1:0] weights [VERTICES][VERTICES];
        logic [FIELD_VW-1:0] sink;
        key_report_t         expected_keys[$];
        int                  errors;
        int                  checked;
        int                  jobs;

        function new();
            clear_graph();
            sink    = 4'd15;
            errors  = 0;
            checked = 0;
            jobs    = 0;
        endfunction

        function void clear_graph();
            foreach (weights[i, j])
                weights[i][j] = '0;
        endfunction

        function int pending();
            return expected_keys.size();
        endfunction

        function void note_edge(logic [FIELD_VW-1:0] s, logic [FIELD_VW-1:0] d,
                                logic [WEIGHT_W-1:0] w, logic closing);
            if (s < VERTICES && d < VERTICES)
                weights[s][d] = w;
            if (closing)
            begin
                solve_job();
                jobs++;
            end
        endfunction

        // Forward pass for earliest times, reverse topological pass for latest
        // times, then every vertex whose two times agree, lowest first.
        function void solve_job();
            logic [TIME_W-1:0] early [VERTICES];
            int                late [VERTICES];
            int                order [VERTICES];
            int                pend [VERTICES];
            bit                hit [VERTICES];
            int                n_ord, head, u, v, x, k, t, cnt, top, sink_idx;
            logic [TIME_W-1:0] span;
            n_ord = 0;
            for (v = 0; v < VERTICES; v++)
            begin
                cnt = 0;
                for (u = 0; u < VERTICES; u++)
                    if (weights[u][v] != 0)
                        cnt++;
                pend[v]  = cnt;
                early[v] = '0;
                if (cnt == 0)
                begin
                    order[n_ord] = v;
                    n_ord++;
                end
            end
            head = 0;
            while (head < n_ord)
            begin
                u = order[head];
                head++;
                for (v = 0; v < VERTICES; v++)
                begin
                    if (weights[u][v] == 0)
                        continue;
                    if (pend[v] != 0)
                    begin
                        pend[v]--;
                        if (pend[v] == 0 && n_ord < VERTICES)
                        begin
                            order[n_ord] = v;
                            n_ord++;
                        end
                    end
                    t = int'(early[u]) + int'(weights[u][v]);
                    if (t > 65535)
                        t = 65535;
                    if (t > int'(early[v]))
                        early[v] = t[TIME_W-1:0];
                end
            end

            sink_idx = (sink < VERTICES) ? int'(sink) : VERTICES - 1;
            span     = early[sink_idx];
            for (x = 0; x < VERTICES; x++)
                late[x] = int'(span);
            for (k = n_ord; k > 0; k--)
            begin
                v = order[k-1];
                for (x = 0; x < VERTICES; x++)
                    if (weights[x][v] != 0 && late[v] - int'(weights[x][v]) < late[x])
                        late[x] = late[v] - int'(weights[x][v]);
            end

            top = -1;
            for (v = 0; v < VERTICES; v++)
            begin
                hit[v] = (v < KEY_LIM) && (int'(early[v]) == late[v]);
                if (hit[v])
                    top = v;
            end
            if (top < 0)
                expected_keys.push_back(key_report_t'{vertex: '0, length: span,
                                                      found: 1'b0, closes: 1'b1});
            else
                for (v = 0; v < VERTICES; v++)
                    if (hit[v])
                        expected_keys.push_back(key_report_t'{vertex: v[FIELD_VW-1:0],
                                                              length: span, found: 1'b1,
                                                              closes: (v == top)});
            clear_graph();
        endfunction

        function void compare(string what, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
            end
        endfunction

        function void check_key(key_report_t got);
            key_report_t want;
            if (expected_keys.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected report, expected none, actual %s%0d %0d %0b %0b",
                         $time, "vertex/len/found/last=", got.vertex, got.length,
                         got.found, got.closes);
                return;
            end
            want = expected_keys.pop_front();
            checked++;
            compare("key_vertex", want.vertex, got.vertex);
            compare("path_length", want.length, got.length);
            compare("found", want.found, got.found);
            compare("last_result", want.closes, got.closes);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cpkv_edge_if edges ();
    cpkv_key_if  keys ();

    critical_path_key_vertices_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .edges   (edges),
        .keys    (keys),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    key_vertex_tracker tracker;
    int                cycles     = 0;
    int                sent_items = 0;
    int                burst_left = 0;
    int                sink_writes = 0;
    stall_mode_e       stall_mode = FLOW;
    int                mode_left  = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("critical_path_key_vertices_top_test: done, errors");
            $finish;
        end
    end

    // Receiver: ready follows a stall pattern that changes every so often.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
            FLOW:    keys.ready = 1'b1;
            COIN:    keys.ready = 1'($urandom_range(0, 1));
            SPARSE:  keys.ready = ($urandom_range(0, 3) == 0);
            default: keys.ready = ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge clk)
        if (rst_n && keys.valid && keys.ready)
            tracker.check_key(key_report_t'{vertex: keys.key_vertex, length: keys.path_length,
                                            found: keys.found, closes: keys.last_result});

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 8'd255;
            2:       return 8'd1;
            default: return WEIGHT_W'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic idle_edges();
        edges.valid       = 1'b0;
        edges.src_vertex  = FIELD_VW'($urandom);
        edges.dst_vertex  = FIELD_VW'($urandom);
        edges.edge_weight = WEIGHT_W'($urandom);
        edges.last_edge   = 1'($urandom);
    endtask

    // Sender works in bursts; between bursts valid drops for a random gap.
    task automatic push_edge(input logic [FIELD_VW-1:0] s, input logic [FIELD_VW-1:0] d,
                             input logic [WEIGHT_W-1:0] w, input logic closing);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            idle_edges();
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        @(negedge clk);
        edges.valid       = 1'b1;
        edges.src_vertex  = s;
        edges.dst_vertex  = d;
        edges.edge_weight = w;
        edges.last_edge   = closing;
        do @(posedge clk); while (!edges.ready);
        tracker.note_edge(s, d, w, closing);
        sent_items++;
        burst_left--;
    endtask

    // Stop sending and wait for every outstanding report.
    task automatic settle();
        @(negedge clk);
        idle_edges();
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_sink(input logic [FIELD_VW-1:0] val);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = REG_SINK;
        pwdata  = 32'(val);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        tracker.sink = val;
        sink_writes++;
        // read back
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        tracker.compare("sink_vertex readback", val, prdata[FIELD_VW-1:0]);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic run_job(input bit noisy);
        int n, i, a, b, lo;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
        for (i = 0; i < n; i++)
        begin
            a = $urandom_range(0, 15);
            b = $urandom_range(0, 15);
            if (!noisy)
            begin
                // forward edges only, so the graph stays acyclic
                b  = $urandom_range(0, 14);
                if (b >= a)
                    b++;
                lo = (a < b) ? a : b;
                b  = (a < b) ? b : a;
                a  = lo;
                if (i == n - 1 && tracker.sink != 0 && $urandom_range(0, 1))
                begin
                    a = $urandom_range(0, tracker.sink - 1);
                    b = tracker.sink;
                end
            end
            push_edge(a[FIELD_VW-1:0], b[FIELD_VW-1:0], pick_weight(), i == n - 1);
        end
    endtask

    initial
    begin
        int phase;
        int rand_start;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        keys.ready        = 1'b0;
        edges.valid       = 1'b0;
        edges.src_vertex  = '0;
        edges.dst_vertex  = '0;
        edges.edge_weight = '0;
        edges.last_edge   = 1'b0;
        tracker = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_sink(4'd15);
        // empty graph: every vertex is key, zero length
        push_edge(4'd15, 4'd15, 8'd0, 1'b1);
        // chain with heaviest weight, an edge written then removed
        push_edge(4'd0, 4'd1, 8'd255, 1'b0);
        push_edge(4'd1, 4'd2, 8'd1, 1'b0);
        push_edge(4'd5, 4'd6, 8'd10, 1'b0);
        push_edge(4'd5, 4'd6, 8'd0, 1'b0);
        push_edge(4'd2, 4'd15, 8'd128, 1'b0);
        push_edge(4'd3, 4'd4, 8'd7, 1'b0);
        push_edge(4'd14, 4'd15, 8'd255, 1'b1);
        // sink with an outgoing edge: no vertex is key
        push_edge(4'd0, 4'd15, 8'd10, 1'b0);
        push_edge(4'd15, 4'd1, 8'd1, 1'b1);
        // self loop and a two-vertex cycle
        push_edge(4'd3, 4'd3, 8'd1, 1'b0);
        push_edge(4'd4, 4'd5, 8'd2, 1'b0);
        push_edge(4'd5, 4'd4, 8'd3, 1'b1);
        settle();
        write_sink(4'd0);
        push_edge(4'd0, 4'd1, 8'd9, 1'b0);
        push_edge(4'd2, 4'd0, 8'd4, 1'b0);
        push_edge(4'd1, 4'd3, 8'd200, 1'b1);
        settle();
        write_sink(4'd7);
        // diamond into the sink with one edge out of it
        push_edge(4'd0, 4'd1, 8'd5, 1'b0);
        push_edge(4'd0, 4'd2, 8'd3, 1'b0);
        push_edge(4'd1, 4'd7, 8'd4, 1'b0);
        push_edge(4'd2, 4'd7, 8'd9, 1'b0);
        push_edge(4'd7, 4'd8, 8'd1, 1'b1);

        rand_start = sent_items;
        phase      = 0;
        while (sent_items - rand_start < RANDOM_ITEMS)
        begin
            settle();
            case (phase)
                0:       write_sink(4'd0);
                1:       write_sink(4'd15);
                default: write_sink(FIELD_VW'($urandom_range(0, 15)));
            endcase
            repeat (5) run_job($urandom_range(0, 5) == 0);
            phase++;
        end
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d jobs of %0d edge items over %0d sink settings",
                 tracker.jobs, sent_items, sink_writes);
        $display("checked %0d key reports, %0d mismatches", tracker.checked, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("critical_path_key_vertices_top_test: done, clean");
        else
            $display("critical_path_key_vertices_top_test: done, errors");
        $finish;
    end

endmodule
